[rtl/core/sacache_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sacache_pkg;

	// cache geometry
	localparam int WAYS       = 8;
	localparam int LINE_BYTES = 32;
	localparam int CACHE_KB   = 64;
	localparam int AGE_BITS   = 16;

	localparam int ADDR_W = 32;
	localparam int COST_W = 8;
	localparam int CYC_W  = 9;
	localparam int WAYO_W = 3;

	// cycles added when the replaced line is dirty
	localparam logic [CYC_W-1:0] EXTRA_DIRTY     = 9'd2;
	localparam logic [COST_W-1:0] MISS_COST_RESET = 8'd42;

	function automatic int floor_log2(input int v);
		int n;
		int x;
		n = 0;
		x = v;
		while (x > 1) begin
			x = x >> 1;
			n++;
		end
		return n;
	endfunction

	localparam int RAW_SETS = (CACHE_KB * 1024) / (LINE_BYTES * WAYS);
	localparam int NUM_SETS = (RAW_SETS > 0) ? RAW_SETS : 1;
	localparam int OFF_BITS = floor_log2(LINE_BYTES);
	localparam int IDX_BITS = floor_log2(NUM_SETS);
	localparam int LOW_BITS = OFF_BITS + IDX_BITS;
	localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int TAG_W    = (LOW_BITS < ADDR_W) ? (ADDR_W - LOW_BITS) : 1;
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

	localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

	// one way of a set
	typedef struct packed {
		logic                valid;
		logic                dirty;
		logic [TAG_W-1:0]    tag;
		logic [AGE_BITS-1:0] age;
	} line_t;

	typedef line_t [WAYS-1:0] row_t;

	// one-hot control states
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_LOOK = 2'b10
	} state_t;

endpackage

`default_nettype wire

[rtl/core/set_assoc_lru_writeback_cache_tags.sv]
// Tag store of a set-associative write-back cache with age-counter LRU.
// Input channel (in_valid / in_stall) takes one access word: address and
// is_store. Output channel (out_valid / out_stall) returns one result word
// per access: hit, way_used, dirty_eviction and cycles_added.
// Config channel (cfg_valid / cfg_ready / cfg_data) writes miss_cost; it is
// always ready and should be written only while the block is idle.
// An access reads the whole set row from the tag memory at the accept edge;
// at the update edge it compares tags, picks the victim, writes the updated
// row back and loads the output register. The single set row memory port
// means that a new access is accepted only once the previous row has been
// written back, so same-set accesses never overlap.
// If the output register still holds an untaken result, the update waits
// in its lookup state until the receiver takes that word.
// Reset clears the per-set valid flags in flip-flops, so every set reads as
// empty right after reset with no clearing pass; miss_cost returns to 42.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_writeback_cache_tags (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [sacache_pkg::COST_W-1:0]   cfg_data,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire  [sacache_pkg::ADDR_W-1:0]   address,
	input  wire                              is_store,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic                             hit,
	output logic [sacache_pkg::WAYO_W-1:0]   way_used,
	output logic                             dirty_eviction,
	output logic [sacache_pkg::CYC_W-1:0]    cycles_added
);
	import sacache_pkg::*;

	state_t              state_q;
	logic [COST_W-1:0]   miss_cost_q;
	logic                in_acc;
	logic                out_acc;
	logic                fire;

	// address split
	logic [ADDR_W-1:0]   set_full;
	logic [ADDR_W-1:0]   tag_full;
	logic [SET_W-1:0]    in_set;
	logic [TAG_W-1:0]    in_tag;

	// lookup stage registers
	logic [SET_W-1:0]    set_s1;
	logic [TAG_W-1:0]    tag_s1;
	logic                store_s1;
	row_t                rd_row_s1;
	logic                row_vld_s1;

	// memory and per-set valid flags
	row_t                mem [NUM_SETS];
	logic [NUM_SETS-1:0] row_vld_q;

	// lookup results
	row_t                row;
	row_t                new_row;
	logic                hit_c;
	logic [WAY_W-1:0]    hit_way;
	logic [WAY_W-1:0]    vic_way;
	logic [WAY_W-1:0]    use_way;
	logic                dev_c;
	logic [CYC_W-1:0]    cyc_c;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid && !out_stall;
	assign fire      = (state_q == S_LOOK) && (!out_valid || !out_stall);

	// set index and tag of the incoming address
	always_comb begin
		set_full = (address >> OFF_BITS) & ((ADDR_W'(1) << IDX_BITS) - ADDR_W'(1));
		tag_full = (LOW_BITS < ADDR_W) ? (address >> LOW_BITS) : '0;
		if (set_full >= ADDR_W'(NUM_SETS)) begin
			in_set = '0;
		end else begin
			in_set = set_full[SET_W-1:0];
		end
		in_tag = tag_full[TAG_W-1:0];
	end

	// miss cost register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_cost_q <= MISS_COST_RESET;
		end else if (cfg_valid && cfg_ready) begin
			miss_cost_q <= cfg_data;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) state_q <= S_LOOK;
				end
				S_LOOK: begin
					if (fire) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// tag memory: row read on accept, row write-back on update
	always_ff @(posedge clk) begin
		if (fire) begin
			mem[set_s1] <= new_row;
		end
		if (in_acc) begin
			rd_row_s1 <= mem[in_set];
		end
	end

	// access held for the lookup state
	always_ff @(posedge clk) begin
		if (in_acc) begin
			set_s1   <= in_set;
			tag_s1   <= in_tag;
			store_s1 <= is_store;
		end
	end

	// per-set valid flags, an unwritten set reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q  <= '0;
			row_vld_s1 <= 1'b0;
		end else begin
			if (fire) row_vld_q[set_s1] <= 1'b1;
			if (in_acc) row_vld_s1 <= row_vld_q[in_set];
		end
	end

	// tag compare, victim search and row update
	always_comb begin
		row     = row_vld_s1 ? rd_row_s1 : '0;
		hit_c   = 1'b0;
		hit_way = '0;
		for (int a = WAYS - 1; a >= 0; a--) begin
			if (row[a].valid && (row[a].tag == tag_s1)) begin
				hit_c   = 1'b1;
				hit_way = WAY_W'(a);
			end
		end
		vic_way = '0;
		for (int a = 1; a < WAYS; a++) begin
			if (row[a].age > row[vic_way].age) vic_way = WAY_W'(a);
		end
		use_way = hit_c ? hit_way : vic_way;
		dev_c   = !hit_c && row[vic_way].dirty;
		if (hit_c) begin
			cyc_c = '0;
		end else begin
			cyc_c = {1'b0, miss_cost_q} + (dev_c ? EXTRA_DIRTY : '0);
		end
		new_row = row;
		for (int a = 0; a < WAYS; a++) begin
			if (row[a].age != AGE_MAX) new_row[a].age = row[a].age + AGE_BITS'(1);
		end
		new_row[use_way].age = '0;
		if (!hit_c) begin
			new_row[use_way].tag   = tag_s1;
			new_row[use_way].valid = 1'b1;
			new_row[use_way].dirty = 1'b0;
		end
		if (store_s1) new_row[use_way].dirty = 1'b1;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fire) begin
			out_valid <= 1'b1;
		end else if (out_acc) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			hit            <= hit_c;
			way_used       <= WAYO_W'(use_way);
			dirty_eviction <= dev_c;
			cycles_added   <= cyc_c;
		end
	end

	// checks
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("control state not one-hot");

	a_hit_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> (cycles_added == '0) && !dirty_eviction)
		else $error("hit word carries a miss charge");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("access accepted while an update is due");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cycles_added))
		else $error("stalled result word lost");

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import sacache_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SAT_HITS    = 24;
	localparam int POOL_SETS   = 4;
	localparam int POOL_TAGS   = 16;

	// one expected result word
	typedef struct packed {
		logic              hit;
		logic [WAYO_W-1:0] way;
		logic              dirty_ev;
		logic [CYC_W-1:0]  cycles;
	} result_word_t;

	// tag store predictor and queue of result words still owed by the block
	class tag_scoreboard;
		bit                  valid_bits [NUM_SETS*WAYS];
		bit                  dirty_bits [NUM_SETS*WAYS];
		logic [TAG_W-1:0]    tags       [NUM_SETS*WAYS];
		logic [AGE_BITS-1:0] ages       [NUM_SETS*WAYS];
		logic [COST_W-1:0]   miss_cost;
		result_word_t        owed_words [$];
		int                  errors;

		function new();
			foreach (valid_bits[i]) begin
				valid_bits[i] = 0;
				dirty_bits[i] = 0;
				tags[i] = '0;
				ages[i] = '0;
			end
			miss_cost = MISS_COST_RESET;
			errors = 0;
		endfunction

		function void set_cost(logic [COST_W-1:0] v);
			miss_cost = v;
		endfunction

		function int owed();
			return owed_words.size();
		endfunction

		// lookup, victim choice and row update for one accepted access word
		function void note_access(logic [ADDR_W-1:0] a, logic st);
			int unsigned  set_idx;
			int unsigned  base;
			logic [TAG_W-1:0] t;
			int           w;
			int           i;
			result_word_t r;
			set_idx = (a >> OFF_BITS) & ((1 << IDX_BITS) - 1);
			t = TAG_W'(a >> LOW_BITS);
			base = set_idx * WAYS;
			r = '0;
			w = 0;
			// lowest valid matching way wins
			for (i = 0; i < WAYS; i++) begin
				if (!r.hit && valid_bits[base+i] && tags[base+i] == t) begin
					r.hit = 1'b1;
					w = i;
				end
			end
			// miss: oldest way, ties to the lowest, no preference for invalid ways
			if (!r.hit) begin
				for (i = 1; i < WAYS; i++) begin
					if (ages[base+i] > ages[base+w])
						w = i;
				end
				r.cycles = CYC_W'(miss_cost);
				if (dirty_bits[base+w]) begin
					r.dirty_ev = 1'b1;
					r.cycles = r.cycles + EXTRA_DIRTY;
				end
				tags[base+w] = t;
				valid_bits[base+w] = 1;
				dirty_bits[base+w] = 0;
			end
			// saturating age bump, then the used way becomes youngest
			for (i = 0; i < WAYS; i++) begin
				if (ages[base+i] != AGE_MAX)
					ages[base+i] = ages[base+i] + 1'b1;
			end
			ages[base+w] = '0;
			if (st)
				dirty_bits[base+w] = 1;
			r.way = WAYO_W'(w);
			owed_words.push_back(r);
		endfunction

		// compare one taken result word against the oldest owed word
		function void check_word(result_word_t got);
			result_word_t want;
			if (owed_words.size() == 0) begin
				$error("result word with no access outstanding");
				errors++;
				return;
			end
			want = owed_words.pop_front();
			if (got.hit !== want.hit) begin
				$error("hit: expected %0d, got %0d", want.hit, got.hit);
				errors++;
			end
			if (got.way !== want.way) begin
				$error("way_used: expected %0d, got %0d", want.way, got.way);
				errors++;
			end
			if (got.dirty_ev !== want.dirty_ev) begin
				$error("dirty_eviction: expected %0d, got %0d", want.dirty_ev, got.dirty_ev);
				errors++;
			end
			if (got.cycles !== want.cycles) begin
				$error("cycles_added: expected %0d, got %0d", want.cycles, got.cycles);
				errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [COST_W-1:0]   cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [ADDR_W-1:0]   address = '0;
	logic                is_store = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                hit;
	logic [WAYO_W-1:0]   way_used;
	logic                dirty_eviction;
	logic [CYC_W-1:0]    cycles_added;

	tag_scoreboard       sb = new();
	bit                  quiet = 1'b0;
	int                  stall_left = 0;
	int                  cycle_count = 0;
	logic [IDX_BITS-1:0] set_pool [POOL_SETS];
	logic [TAG_W-1:0]    tag_pool [POOL_TAGS];
	int                  tags_in_use = POOL_TAGS;

	set_assoc_lru_writeback_cache_tags uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.address        (address),
		.is_store       (is_store),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.hit            (hit),
		.way_used       (way_used),
		.dirty_eviction (dirty_eviction),
		.cycles_added   (cycles_added)
	);

	// clock
	always #(CLK_HALF) clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// result words taken by the receiver
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_word({hit, way_used, dirty_eviction, cycles_added});
	end

	// gap lengths: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return $urandom_range(1, 2);
		else if (r < 93)
			return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	// receiver stalls
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall = 1'b1;
			stall_left--;
		end else begin
			out_stall = 1'b0;
			if (!quiet && $urandom_range(0, 99) < 25)
				stall_left = pick_gap();
		end
	end

	function automatic logic [ADDR_W-1:0] mk_addr(logic [TAG_W-1:0] t,
			logic [IDX_BITS-1:0] s, logic [OFF_BITS-1:0] o);
		return {t, s, o};
	endfunction

	// mostly a small pool of sets and tags so lines get reused and evicted
	function automatic logic [ADDR_W-1:0] random_address();
		if ($urandom_range(0, 99) < 12)
			return $urandom();
		return mk_addr(tag_pool[$urandom_range(0, tags_in_use - 1)],
			set_pool[$urandom_range(0, POOL_SETS - 1)], OFF_BITS'($urandom()));
	endfunction

	function automatic void refill_pools();
		foreach (set_pool[i])
			set_pool[i] = IDX_BITS'($urandom());
		foreach (tag_pool[i])
			tag_pool[i] = TAG_W'($urandom());
		tags_in_use = $urandom_range(9, POOL_TAGS);
	endfunction

	// offer one access word, called at a falling edge, returns at a falling edge
	task automatic send_access(logic [ADDR_W-1:0] a, logic st);
		int n;
		n = 0;
		if (!quiet && $urandom_range(0, 99) < 30)
			n = pick_gap();
		if (n > 0) begin
			in_valid = 1'b0;
			repeat (n) @(negedge clk);
		end
		in_valid = 1'b1;
		address = a;
		is_store = st;
		do @(posedge clk); while (in_stall);
		sb.note_access(a, st);
		@(negedge clk);
	endtask

	// stop offering and wait until every owed word has come back
	task automatic drain();
		in_valid = 1'b0;
		while (sb.owed() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// miss cost write while the block is idle
	task automatic write_cost(logic [COST_W-1:0] v);
		drain();
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_cost(v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// stimulus
	initial begin
		logic [COST_W-1:0]   costs [5];
		logic [IDX_BITS-1:0] sat_set;
		logic [TAG_W-1:0]    sat_tag;
		int                  p;
		int                  k;
		costs[0] = 8'd0;
		costs[1] = 8'd255;
		costs[2] = COST_W'($urandom());
		costs[3] = 8'd1;
		costs[4] = COST_W'($urandom());

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty set, offset extremes, fill, lru victims, dirty victim
		send_access(32'h0000_0000, 1'b0);
		send_access(32'h0000_001F, 1'b0);
		for (k = 1; k < WAYS; k++)
			send_access(mk_addr(TAG_W'(k), '0, '0), 1'b1);
		send_access(mk_addr(TAG_W'(3), '0, '1), 1'b1);
		send_access(mk_addr(TAG_W'(8), '0, '0), 1'b0);
		send_access(mk_addr(TAG_W'(9), '0, '0), 1'b0);
		send_access(32'hFFFF_FFFF, 1'b1);
		send_access(32'hFFFF_FFE0, 1'b0);
		send_access(mk_addr('1, '0, '0), 1'b0);
		send_access(mk_addr('0, '1, '0), 1'b0);
		send_access(32'hAAAA_AAAA, 1'b1);
		send_access(32'h5555_5555, 1'b0);

		// random phases across miss cost settings
		for (p = 0; p < 5; p++) begin
			write_cost(costs[p]);
			refill_pools();
			for (k = 0; k < 230; k++) begin
				if (k % 46 == 0)
					quiet = ($urandom_range(0, 3) == 0);
				send_access(random_address(), 1'($urandom()));
			end
			quiet = 1'b0;
		end

		// lru order: fill a set, keep hitting its first line while the others age, then miss
		write_cost(8'd200);
		quiet = 1'b1;
		sat_set = IDX_BITS'($urandom());
		sat_tag = TAG_W'($urandom());
		for (k = 0; k < WAYS; k++)
			send_access(mk_addr(sat_tag + TAG_W'(k), sat_set, '0), 1'(k));
		repeat (SAT_HITS)
			send_access(mk_addr(sat_tag, sat_set, OFF_BITS'($urandom())), 1'b0);
		send_access(mk_addr(sat_tag + TAG_W'(WAYS), sat_set, '0), 1'b0);
		send_access(mk_addr(sat_tag + TAG_W'(WAYS + 1), sat_set, '0), 1'b1);
		send_access(mk_addr(sat_tag + TAG_W'(WAYS + 1), sat_set, '1), 1'b0);
		quiet = 1'b0;

		// wrap up
		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.owed() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
